// ----- hw/rtl/ggn_pkg.sv -----
// Shared types, constants and helpers for the grid gradient normal stencil.
// No dependencies.
package ggn_pkg;
	localparam int MaxGrid   = 256;
	localparam int SampleW   = 16;
	localparam int DiffW     = SampleW + 1;
	localparam int RootW     = 25;
	localparam int NumW      = 40;
	localparam int MagW      = 26;
	localparam int NormW     = 16;
	localparam logic [8:0] GridMin = 9'd3;
	localparam logic [8:0] GridMax = 9'(MaxGrid);
	localparam logic [NumW-1:0] UnitOne = NumW'(16384);

	localparam logic REG_GRID_SIZE = 1'b0;
	localparam logic REG_INV_TWO_DX = 1'b1;

	typedef struct packed {
		logic            start;
		logic [NumW-1:0] num;
		logic [RootW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [NumW-1:0] quot;
	} div_rsp_t;

	function automatic logic [NormW-1:0] unit_part(input logic neg, input logic [NumW-1:0] q);
		logic [NormW-1:0] c;
		c = (q > UnitOne) ? NormW'(16384) : q[NormW-1:0];
		return neg ? (~c + 1'b1) : c;
	endfunction
endpackage

// ----- hw/rtl/ggn_if.sv -----
// Request channel interfaces for samples and results.
// Depends on ggn_pkg.
interface ggn_sample_if;
	logic                               valid;
	logic                               ready;
	logic signed [ggn_pkg::SampleW-1:0] phi_sample;
	modport source (output valid, output phi_sample, input ready);
	modport sink (input valid, input phi_sample, output ready);
endinterface

interface ggn_result_if;
	logic                              valid;
	logic                              ready;
	logic [ggn_pkg::MagW-1:0]          grad_magnitude;
	logic signed [ggn_pkg::NormW-1:0]  normal_x;
	logic signed [ggn_pkg::NormW-1:0]  normal_y;
	logic [7:0]                        centre_row;
	logic [7:0]                        centre_col;
	logic                              frame_last;
	modport source (output valid, output grad_magnitude, output normal_x, output normal_y,
		output centre_row, output centre_col, output frame_last, input ready);
	modport sink (input valid, input grad_magnitude, input normal_x, input normal_y,
		input centre_row, input centre_col, input frame_last, output ready);
endinterface

// ----- hw/rtl/grid_gradient_normal_stencil_top.sv -----
// Top level of the grid gradient normal stencil: line stores, window, root, scaling.
// Depends on ggn_pkg, ggn_if and ggn_div.
//
// Samples of a square grid enter on the sample channel in raster order, one request
// each. For every interior point one request leaves on the result channel carrying the
// gradient magnitude, the unit normal, the centre position and a last-of-grid flag.
// The result for centre (r-1, c-1) belongs to the sample at (r, c).
// Two 256-entry line stores with registered reads hold the two previous rows;
// each sample reads them at its column and writes them back the next cycle.
// A border sample passes through READ and returns to IDLE. An interior sample holds the input
// until its result is loaded into the output register: the bit-serial square root and
// two serial divisions for the normal components dominate; a point whose magnitude
// rounds to zero skips the divisions. One sample is processed at a time.
// The result sits in an output register: a stalled receiver holds it, and the next
// sample is still accepted; it waits only when its own result is ready.
// Reset clears counters and window registers and sets grid_size to 256 and
// inv_two_dx to 128; line store contents are undefined until written.
// Registers: grid_size at address 0, inv_two_dx at address 4, APB write and read.
module grid_gradient_normal_stencil_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	ggn_sample_if.sink          sample,
	ggn_result_if.source        result
);
	localparam int DiffW = ggn_pkg::DiffW;

	typedef enum logic [3:0] {
		IDLE, READ, SQ, SUM, ROOT, MUL, NORM, DIVX, DIVY, OUT
	} state_t;

	state_t state_q;
	logic [8:0]  grid_size_q;
	logic [15:0] inv_q;

	logic signed [ggn_pkg::SampleW-1:0] up_mem [ggn_pkg::MaxGrid];
	logic signed [ggn_pkg::SampleW-1:0] mid_mem [ggn_pkg::MaxGrid];
	logic signed [ggn_pkg::SampleW-1:0] up_rd_q, mid_rd_q;

	logic [7:0] row_q, col_q, r_s1, c_s1;
	logic       emit_s1, last_s1;
	logic signed [ggn_pkg::SampleW-1:0] s_s1, prev_q, midb1_q, midb2_q, upb1_q;
	logic signed [ggn_pkg::DiffW-1:0]   dx_q, dy_q, dx_n, dy_n;
	logic [ggn_pkg::DiffW-1:0]          adx_q, ady_q;
	logic [31:0] sqx_q, sqy_q;
	logic [49:0] rad_q;
	logic [27:0] rem_q, rem2, trial;
	logic [ggn_pkg::RootW-1:0] root_q;
	logic [4:0]  rcnt_q;
	logic [ggn_pkg::MagW-1:0]  mag_q;
	logic [41:0] prod;
	logic [ggn_pkg::NormW-1:0] nx_q, ny_q;

	logic [8:0] g, c9, r9, cn, rn, c1, r1;
	logic       acc, cfg_wr, load_out;

	ggn_pkg::div_req_t div_req;
	ggn_pkg::div_rsp_t div_rsp;

	ggn_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == ggn_pkg::REG_INV_TWO_DX) ? {16'd0, inv_q} : {23'd0, grid_size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= 9'd256;
			inv_q       <= 16'd128;
		end else if (cfg_wr) begin
			if (paddr[2] == ggn_pkg::REG_GRID_SIZE) grid_size_q <= pwdata[8:0];
			else inv_q <= pwdata[15:0];
		end
	end

	// position
	always_comb begin
		g  = (grid_size_q < ggn_pkg::GridMin) ? ggn_pkg::GridMin :
		     (grid_size_q > ggn_pkg::GridMax) ? ggn_pkg::GridMax : grid_size_q;
		c9 = {1'b0, col_q};
		r9 = {1'b0, row_q};
		if (c9 >= g) begin
			cn = '0;
			r9 = r9 + 9'd1;
		end else begin
			cn = c9;
		end
		rn = (r9 >= g) ? 9'd0 : r9;
		c1 = cn + 9'd1;
		r1 = rn;
		if (c1 >= g) begin
			c1 = '0;
			r1 = rn + 9'd1;
			if (r1 >= g) r1 = '0;
		end
	end

	assign acc          = sample.valid && sample.ready;
	assign sample.ready = (state_q == IDLE);

	always_ff @(posedge clk) begin
		if (acc) begin
			up_rd_q  <= up_mem[cn[7:0]];
			mid_rd_q <= mid_mem[cn[7:0]];
		end
		if (state_q == READ) begin
			up_mem[c_s1]  <= mid_rd_q;
			mid_mem[c_s1] <= s_s1;
		end
	end

	assign dx_n = DiffW'(prev_q) - DiffW'(upb1_q);
	assign dy_n = DiffW'(mid_rd_q) - DiffW'(midb2_q);

	assign rem2  = {rem_q[25:0], rad_q[49:48]};
	assign trial = {1'b0, root_q, 2'b01};
	assign prod  = 42'(root_q) * 42'(inv_q) + 42'd32768;

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = ggn_pkg::NumW'({adx_q, 22'd0}) +
			ggn_pkg::NumW'(root_q[ggn_pkg::RootW-1:1]);
		div_req.den   = root_q;
		if (state_q == NORM && mag_q != '0) div_req.start = 1'b1;
		if (state_q == DIVX && div_rsp.done) begin
			div_req.start = 1'b1;
			div_req.num   = ggn_pkg::NumW'({ady_q, 22'd0}) +
				ggn_pkg::NumW'(root_q[ggn_pkg::RootW-1:1]);
		end
	end

	assign load_out = (state_q == OUT) && (!result.valid || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			row_q        <= '0;
			col_q        <= '0;
			prev_q       <= '0;
			midb1_q      <= '0;
			midb2_q      <= '0;
			upb1_q       <= '0;
			result.valid <= 1'b0;
		end else begin
			if (load_out) result.valid <= 1'b1;
			else if (result.ready) result.valid <= 1'b0;
			unique case (state_q)
				IDLE: if (acc) begin
					state_q <= READ;
					row_q   <= r1[7:0];
					col_q   <= c1[7:0];
				end
				READ: begin
					prev_q  <= s_s1;
					midb1_q <= mid_rd_q;
					midb2_q <= midb1_q;
					upb1_q  <= up_rd_q;
					state_q <= emit_s1 ? SQ : IDLE;
				end
				SQ:   state_q <= SUM;
				SUM:  state_q <= ROOT;
				ROOT: if (rcnt_q == 5'd0) state_q <= MUL;
				MUL:  state_q <= NORM;
				NORM: state_q <= (mag_q == '0) ? OUT : DIVX;
				DIVX: if (div_rsp.done) state_q <= DIVY;
				DIVY: if (div_rsp.done) state_q <= OUT;
				OUT:  if (load_out) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s_s1    <= sample.phi_sample;
			r_s1    <= rn[7:0];
			c_s1    <= cn[7:0];
			emit_s1 <= (rn >= 9'd2) && (cn >= 9'd2);
			last_s1 <= (rn == g - 9'd1) && (cn == g - 9'd1);
		end
		if (state_q == READ) begin
			dx_q <= dx_n;
			dy_q <= dy_n;
		end
		if (state_q == SQ) begin
			adx_q <= dx_q[DiffW-1] ? DiffW'(-dx_q) : DiffW'(dx_q);
			ady_q <= dy_q[DiffW-1] ? DiffW'(-dy_q) : DiffW'(dy_q);
			sqx_q <= 32'(dx_q * dx_q);
			sqy_q <= 32'(dy_q * dy_q);
		end
		if (state_q == SUM) begin
			rad_q  <= {34'(sqx_q) + 34'(sqy_q), 16'd0};
			rem_q  <= '0;
			root_q <= '0;
			rcnt_q <= 5'(ggn_pkg::RootW - 1);
		end
		if (state_q == ROOT) begin
			rad_q  <= {rad_q[47:0], 2'b00};
			rcnt_q <= rcnt_q - 5'd1;
			if (rem2 >= trial) begin
				rem_q  <= rem2 - trial;
				root_q <= {root_q[ggn_pkg::RootW-2:0], 1'b1};
			end else begin
				rem_q  <= rem2;
				root_q <= {root_q[ggn_pkg::RootW-2:0], 1'b0};
			end
		end
		if (state_q == MUL) mag_q <= prod[41:16];
		if (state_q == NORM) begin
			nx_q <= '0;
			ny_q <= '0;
		end
		if (state_q == DIVX && div_rsp.done) nx_q <= ggn_pkg::unit_part(dx_q[DiffW-1], div_rsp.quot);
		if (state_q == DIVY && div_rsp.done) ny_q <= ggn_pkg::unit_part(dy_q[DiffW-1], div_rsp.quot);
		if (load_out) begin
			result.grad_magnitude <= mag_q;
			result.normal_x       <= nx_q;
			result.normal_y       <= ny_q;
			result.centre_row     <= r_s1 - 8'd1;
			result.centre_col     <= c_s1 - 8'd1;
			result.frame_last     <= last_s1;
		end
	end

`ifndef SYNTHESIS
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q == READ) else $error("accepted sample not read");
	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> result.valid) else $error("result not presented");
	a_col_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == READ) |-> ({1'b0, c_s1} < g)) else $error("column outside grid");
	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && mag_q == '0) |=> (result.normal_x == '0 && result.normal_y == '0))
		else $error("flat point with nonzero normal");
`endif
endmodule

// ----- hw/rtl/ggn_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ggn_pkg.
module ggn_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ggn_pkg::div_req_t req,
	output ggn_pkg::div_rsp_t rsp
);
	logic                        busy_q, done_q;
	logic [5:0]                  cnt_q;
	logic [ggn_pkg::NumW-1:0]    num_q, quot_q;
	logic [ggn_pkg::RootW-1:0]   den_q;
	logic [ggn_pkg::RootW:0]     rem_q, rem2;
	logic                        ge;

	assign rem2 = {rem_q[ggn_pkg::RootW-1:0], num_q[ggn_pkg::NumW-1]};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(ggn_pkg::NumW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[ggn_pkg::NumW-2:0], 1'b0};
			rem_q  <= ge ? (rem2 - {1'b0, den_q}) : rem2;
			quot_q <= {quot_q[ggn_pkg::NumW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

`ifndef SYNTHESIS
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("divider did not start");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q < 6'(ggn_pkg::NumW)) else $error("divider count overrun");
`endif
endmodule
